[hw/rtl/cscan_disk_scheduler_macros.svh]
// assertion macros of the c-scan scheduler rtl
`ifndef CSCAN_DISK_SCHEDULER_MACROS_SVH
`define CSCAN_DISK_SCHEDULER_MACROS_SVH

`ifndef NO_ASSERTIONS

// expression holds on every clock out of reset
`define CSCAN_ASSERT_ALWAYS(lbl, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
    else $error("cscan assertion failed");

// consequent holds in the same cycle as the antecedent
`define CSCAN_ASSERT_IMPLIES(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("cscan assertion failed");

// consequent holds in the cycle after the antecedent
`define CSCAN_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("cscan assertion failed");

`else

`define CSCAN_ASSERT_ALWAYS(lbl, expr)
`define CSCAN_ASSERT_IMPLIES(lbl, ante, cons)
`define CSCAN_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

[hw/rtl/cscan_pkg.sv]
// shared types and constants of the c-scan scheduler
`timescale 1ns / 1ps
package cscan_pkg;

  localparam int TRAVEL_W = 23;
  typedef logic [TRAVEL_W-1:0] travel_t;
  localparam travel_t TRAVEL_MAX = '1;

  localparam int CFG_W = 16;
  typedef logic [CFG_W-1:0] cfg_word_t;

  localparam int CFG_IDX_W = 2;
  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

  localparam cfg_idx_t REG_DISK_CYLINDERS = 2'd0;
  localparam cfg_idx_t REG_START_HEAD     = 2'd1;
  localparam cfg_idx_t REG_SWEEP_UP       = 2'd2;

  localparam cfg_word_t DISK_CYLINDERS_RESET = 16'd200;

endpackage

[hw/rtl/cscan_disk_scheduler.sv]
// top level of the c-scan disk request scheduler
`timescale 1ns / 1ps
// Collects a batch of cylinder requests (one per request on the in_ stream, the last one marked
// by in_tlast) and returns them in c-scan service order on the out_ stream, each with the
// running head travel; out_tlast marks the last one, whose travel is the batch total. Requests
// are kept sorted as they arrive by insertion into a memory with one write and one read port:
// a request passes a read and a compare state per stored entry larger than it, and in_tready
// is low meanwhile. A request beyond MAX_REQUESTS is dropped, but its tlast still closes the
// batch. After the closing request a scan finds the split point against start_head, with a
// read and a compare state per entry looked at, then a setup state. Each result then passes
// the read, move, output and wait states, waiting for out_tready, and the single sweep-end run
// and wrap come once per batch between the two parts, or on the last result if the second part
// is empty. All distance and saturating travel sums go through one shared accumulator unit.
// Configuration is written through cfg_we, cfg_index and cfg_wdata, read live during each batch.
`include "cscan_disk_scheduler_macros.svh"
module cscan_disk_scheduler
  import cscan_pkg::*;
#(
  parameter int MAX_REQUESTS  = 64,
  parameter int CYLINDER_BITS = 16
) (
  input  logic clk,
  input  logic rst_n,

  // configuration write port
  input  logic             cfg_we,
  input  cfg_idx_t         cfg_index,
  input  cfg_word_t        cfg_wdata,

  // request stream
  input  logic                                  in_tvalid,
  output logic                                  in_tready,
  input  logic [((CYLINDER_BITS+7)/8)*8-1:0]    in_tdata,   // [CYLINDER_BITS-1:0] cylinder
  input  logic                                  in_tlast,   // batch_end

  // service order stream
  output logic                                  out_tvalid,
  input  logic                                  out_tready,
  // served_cylinder from bit 0, then movement_so_far (23 bits), zero padded
  output logic [((CYLINDER_BITS+TRAVEL_W+7)/8)*8-1:0] out_tdata,
  output logic                                  out_tlast   // final_res
);

  localparam int AW   = $clog2(MAX_REQUESTS);
  localparam int CNTW = $clog2(MAX_REQUESTS + 1);
  localparam int OPW  = (CYLINDER_BITS > CFG_W) ? CYLINDER_BITS : CFG_W;
  localparam int OUTW = ((CYLINDER_BITS + TRAVEL_W + 7) / 8) * 8;

  // sequencer states
  localparam logic [3:0] S_LOAD      = 4'd0;
  localparam logic [3:0] S_INS_RD    = 4'd1;
  localparam logic [3:0] S_INS_CMP   = 4'd2;
  localparam logic [3:0] S_SCAN_RD   = 4'd3;
  localparam logic [3:0] S_SCAN_CMP  = 4'd4;
  localparam logic [3:0] S_SETUP     = 4'd5;
  localparam logic [3:0] S_EMIT_RD   = 4'd6;
  localparam logic [3:0] S_EMIT_MOVE = 4'd7;
  localparam logic [3:0] S_WRAP1     = 4'd8;
  localparam logic [3:0] S_WRAP2     = 4'd9;
  localparam logic [3:0] S_OUT       = 4'd10;
  localparam logic [3:0] S_WAIT      = 4'd11;

  // configuration registers
  cfg_word_t disk_cyl_r;
  cfg_word_t start_head_r;
  logic      sweep_up_r;

  // control state
  logic [3:0]      state_r, state_nxt;
  logic [CNTW-1:0] cnt_r, cnt_nxt;
  logic            out_valid_r, out_valid_nxt;

  // working registers
  logic [CNTW-1:0]          j_r, j_nxt;         // insertion slot, later scan index
  logic [CYLINDER_BITS-1:0] val_r, val_nxt;     // request being inserted
  logic                     end_r, end_nxt;     // batch closes after this insertion
  logic [CNTW-1:0]          split_r, split_nxt;
  logic [CNTW-1:0]          pos_r, pos_nxt;     // place in service order
  logic [AW-1:0]            idx_r, idx_nxt;     // store entry being served
  logic                     wrapped_r, wrapped_nxt;
  logic [OPW-1:0]           head_r, head_nxt;
  travel_t                  total_r, total_nxt;
  logic [CYLINDER_BITS-1:0] cur_r, cur_nxt;

  // output register
  logic [CYLINDER_BITS-1:0] out_cyl_r, out_cyl_nxt;
  travel_t                  out_mov_r, out_mov_nxt;
  logic                     out_last_r, out_last_nxt;

  // sorted request memory
  logic [CYLINDER_BITS-1:0] mem [MAX_REQUESTS];
  logic [CYLINDER_BITS-1:0] rdata_r;
  logic                     mem_we;
  logic [AW-1:0]            mem_waddr;
  logic [CYLINDER_BITS-1:0] mem_wdata;
  logic [AW-1:0]            mem_raddr;

  // shared travel unit
  logic [OPW-1:0] unit_a;
  logic [OPW-1:0] unit_b;
  logic           unit_diff;
  travel_t        unit_sum;

  // derived values
  cfg_word_t       last_cyl;
  logic [OPW-1:0]  last_ext;
  logic [CNTW-1:0] jm1;
  logic [CNTW-1:0] cntm1;
  logic [CNTW-1:0] first_len;   // length of the part served before the wrap
  logic [CNTW-1:0] idx_ext;

  // entry just below the split point
  function automatic logic [AW-1:0] jm1_split(input logic [CNTW-1:0] s);
    logic [CNTW-1:0] t;
    t = s - 1'b1;
    return t[AW-1:0];
  endfunction

  assign last_cyl  = (disk_cyl_r == '0) ? '0 : disk_cyl_r - 1'b1;
  assign last_ext  = OPW'(last_cyl);
  assign jm1       = j_r - 1'b1;
  assign cntm1     = cnt_r - 1'b1;
  assign first_len = sweep_up_r ? (cnt_r - split_r) : split_r;
  assign idx_ext   = CNTW'(idx_r);

  cscan_travel_unit #(
    .OPW (OPW)
  ) u_travel (
    .op_a      (unit_a),
    .op_b      (unit_b),
    .use_diff  (unit_diff),
    .total_in  (total_r),
    .total_out (unit_sum)
  );

  // configuration writes, indexes beyond the list are ignored
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      disk_cyl_r   <= DISK_CYLINDERS_RESET;
      start_head_r <= '0;
      sweep_up_r   <= 1'b1;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_DISK_CYLINDERS: disk_cyl_r   <= cfg_wdata;
        REG_START_HEAD:     start_head_r <= cfg_wdata;
        REG_SWEEP_UP:       sweep_up_r   <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // request memory, registered read
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rdata_r <= mem[mem_raddr];
  end

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r;
    j_nxt         = j_r;
    val_nxt       = val_r;
    end_nxt       = end_r;
    split_nxt     = split_r;
    pos_nxt       = pos_r;
    idx_nxt       = idx_r;
    wrapped_nxt   = wrapped_r;
    head_nxt      = head_r;
    total_nxt     = total_r;
    cur_nxt       = cur_r;
    out_cyl_nxt   = out_cyl_r;
    out_mov_nxt   = out_mov_r;
    out_last_nxt  = out_last_r;

    mem_we    = 1'b0;
    mem_waddr = j_r[AW-1:0];
    mem_wdata = val_r;
    mem_raddr = j_r[AW-1:0];

    unit_a    = OPW'(rdata_r);
    unit_b    = head_r;
    unit_diff = 1'b1;

    in_tready = (state_r == S_LOAD);

    case (state_r)
      S_LOAD: begin
        if (in_tvalid) begin
          if (cnt_r < CNTW'(MAX_REQUESTS)) begin
            val_nxt   = in_tdata[CYLINDER_BITS-1:0];
            j_nxt     = cnt_r;
            cnt_nxt   = cnt_r + 1'b1;
            end_nxt   = in_tlast;
            state_nxt = S_INS_RD;
          end else if (in_tlast) begin
            // store full: request dropped, batch still closes
            j_nxt     = '0;
            state_nxt = S_SCAN_RD;
          end
        end
      end

      S_INS_RD: begin
        if (j_r == '0) begin
          mem_we    = 1'b1;
          j_nxt     = '0;
          state_nxt = end_r ? S_SCAN_RD : S_LOAD;
        end else begin
          mem_raddr = jm1[AW-1:0];
          state_nxt = S_INS_CMP;
        end
      end

      S_INS_CMP: begin
        mem_we = 1'b1;
        if (rdata_r > val_r) begin
          // move the larger entry up one slot
          mem_wdata = rdata_r;
          j_nxt     = jm1;
          state_nxt = S_INS_RD;
        end else begin
          j_nxt     = '0;
          state_nxt = end_r ? S_SCAN_RD : S_LOAD;
        end
      end

      S_SCAN_RD: begin
        state_nxt = S_SCAN_CMP;
      end

      S_SCAN_CMP: begin
        if (OPW'(rdata_r) > OPW'(start_head_r)) begin
          split_nxt = j_r;
          state_nxt = S_SETUP;
        end else if (j_r == cntm1) begin
          // nothing above the head: split at the end of the batch
          split_nxt = cnt_r;
          state_nxt = S_SETUP;
        end else begin
          j_nxt     = j_r + 1'b1;
          state_nxt = S_SCAN_RD;
        end
      end

      S_SETUP: begin
        pos_nxt     = '0;
        wrapped_nxt = 1'b0;
        head_nxt    = OPW'(start_head_r);
        total_nxt   = '0;
        if (sweep_up_r) begin
          idx_nxt = (split_r == cnt_r) ? '0 : split_r[AW-1:0];
        end else begin
          idx_nxt = (split_r == '0) ? cntm1[AW-1:0] : jm1_split(split_r);
        end
        state_nxt = S_EMIT_RD;
      end

      S_EMIT_RD: begin
        mem_raddr = idx_r;
        if (pos_r == first_len && !wrapped_r) begin
          state_nxt = S_WRAP1;
        end else begin
          state_nxt = S_EMIT_MOVE;
        end
      end

      S_EMIT_MOVE: begin
        total_nxt = unit_sum;
        head_nxt  = OPW'(rdata_r);
        cur_nxt   = rdata_r;
        // second part empty: sweep-end run and wrap land on the last result
        if (first_len == cnt_r && pos_r == cntm1) begin
          state_nxt = S_WRAP1;
        end else begin
          state_nxt = S_OUT;
        end
      end

      S_WRAP1: begin
        // run to the sweep end
        unit_a    = sweep_up_r ? last_ext : '0;
        total_nxt = unit_sum;
        state_nxt = S_WRAP2;
      end

      S_WRAP2: begin
        // full-stroke return
        unit_a      = last_ext;
        unit_diff   = 1'b0;
        total_nxt   = unit_sum;
        head_nxt    = sweep_up_r ? '0 : last_ext;
        wrapped_nxt = 1'b1;
        state_nxt   = (first_len == cnt_r) ? S_OUT : S_EMIT_RD;
      end

      S_OUT: begin
        out_valid_nxt = 1'b1;
        out_cyl_nxt   = cur_r;
        out_mov_nxt   = total_r;
        out_last_nxt  = (pos_r == cntm1);
        state_nxt     = S_WAIT;
      end

      S_WAIT: begin
        if (out_tready) begin
          out_valid_nxt = 1'b0;
          if (out_last_r) begin
            cnt_nxt   = '0;
            state_nxt = S_LOAD;
          end else begin
            pos_nxt = pos_r + 1'b1;
            if (sweep_up_r) begin
              idx_nxt = (idx_ext == cntm1) ? '0 : idx_r + 1'b1;
            end else begin
              idx_nxt = (idx_r == '0) ? cntm1[AW-1:0] : idx_r - 1'b1;
            end
            state_nxt = S_EMIT_RD;
          end
        end
      end

      default: begin
        state_nxt = S_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_LOAD;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    j_r        <= j_nxt;
    val_r      <= val_nxt;
    end_r      <= end_nxt;
    split_r    <= split_nxt;
    pos_r      <= pos_nxt;
    idx_r      <= idx_nxt;
    wrapped_r  <= wrapped_nxt;
    head_r     <= head_nxt;
    total_r    <= total_nxt;
    cur_r      <= cur_nxt;
    out_cyl_r  <= out_cyl_nxt;
    out_mov_r  <= out_mov_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUTW'({out_mov_r, out_cyl_r});
  assign out_tlast  = out_last_r;

  // requests are never taken while a result is on offer
  `CSCAN_ASSERT_ALWAYS(a_no_overlap, !(in_tready && out_tvalid))
  // the request count stays within the store
  `CSCAN_ASSERT_ALWAYS(a_cnt_bound, cnt_r <= CNTW'(MAX_REQUESTS))
  // the final result frees the store for the next batch
  `CSCAN_ASSERT_NEXT(a_batch_done, out_tvalid && out_tready && out_tlast,
                     cnt_r == '0 && state_r == S_LOAD)
  // served entries lie inside the held batch
  `CSCAN_ASSERT_IMPLIES(a_idx_range, state_r == S_EMIT_RD, idx_ext < cnt_r)
  // the wrap is taken once per batch
  `CSCAN_ASSERT_IMPLIES(a_single_wrap, state_r == S_WRAP1, !wrapped_r)

endmodule

[hw/rtl/cscan_travel_unit.sv]
// shared distance and saturating travel accumulator of the c-scan scheduler
`timescale 1ns / 1ps
module cscan_travel_unit
  import cscan_pkg::*;
#(
  parameter int OPW = 16
) (
  input  logic [OPW-1:0] op_a,
  input  logic [OPW-1:0] op_b,
  input  logic           use_diff,   // 1: add |a - b|, 0: add a
  input  travel_t        total_in,
  output travel_t        total_out
);

  localparam int SW = ((OPW > TRAVEL_W) ? OPW : TRAVEL_W) + 1;

  logic [OPW-1:0] gap;
  logic [OPW-1:0] step;
  logic [SW-1:0]  sum_wide;

  always_comb begin
    if (op_a >= op_b) begin
      gap = op_a - op_b;
    end else begin
      gap = op_b - op_a;
    end
    step      = use_diff ? gap : op_a;
    sum_wide  = SW'(total_in) + SW'(step);
    // clamp at the top of the travel range
    total_out = (sum_wide > SW'(TRAVEL_MAX)) ? TRAVEL_MAX : sum_wide[TRAVEL_W-1:0];
  end

endmodule

[verif/cscan_disk_scheduler_checker.sv]
// checker of the c-scan disk scheduler: predicts the service order and compares results
`timescale 1ns / 1ps
module cscan_disk_scheduler_checker
  import cscan_pkg::*;
#(
  parameter int MAX_REQUESTS  = 64,
  parameter int CYLINDER_BITS = 16
) (
  input  logic clk,
  input  logic rst_n,

  input  logic      cfg_we,
  input  cfg_idx_t  cfg_index,
  input  cfg_word_t cfg_wdata,

  input  logic                                  in_tvalid,
  input  logic                                  in_tready,
  input  logic [((CYLINDER_BITS+7)/8)*8-1:0]    in_tdata,   // cylinder
  input  logic                                  in_tlast,   // batch_end

  input  logic                                  out_tvalid,
  input  logic                                  out_tready,
  // served_cylinder, movement_so_far, zero padding
  input  logic [((CYLINDER_BITS+TRAVEL_W+7)/8)*8-1:0] out_tdata,
  input  logic                                  out_tlast,  // final_res

  output int unsigned fail_count,
  output int unsigned pending_results
);

  typedef logic [CYLINDER_BITS-1:0] cyl_t;

  typedef struct packed {
    cyl_t    cylinder;
    travel_t movement;
    logic    final_res;
  } service_t;

  // register shadows
  cfg_word_t disk_cyls;
  cfg_word_t head_start;
  logic      upward;

  // batch state
  cyl_t     req_mem [MAX_REQUESTS];
  int       req_count;
  cyl_t     head_pos;
  travel_t  travel_acc;
  service_t service_q [$];

  initial begin
    fail_count      = 0;
    pending_results = 0;
  end

  function automatic void add_travel(input longint unsigned span);
    longint unsigned sum;
    sum = longint'(travel_acc) + span;
    travel_acc = (sum > longint'(TRAVEL_MAX)) ? TRAVEL_MAX : travel_t'(sum);
  endfunction

  function automatic void move_head(input cyl_t target);
    longint unsigned span;
    span = (target >= head_pos) ? longint'(target - head_pos) : longint'(head_pos - target);
    add_travel(span);
    head_pos = target;
  endfunction

  // run to the sweep end, then the full-stroke return
  function automatic void sweep_wrap(input cyl_t end_cyl, input cyl_t wrap_to, input cyl_t stroke);
    move_head(end_cyl);
    head_pos = wrap_to;
    add_travel(longint'(stroke));
  endfunction

  function automatic void note_result(input cyl_t cyl, input logic fin);
    service_t s;
    s.cylinder  = cyl;
    s.movement  = travel_acc;
    s.final_res = fin;
    service_q.push_back(s);
  endfunction

  function automatic void schedule_batch();
    int   n, split, i, j;
    cyl_t v, last_cyl;
    n = req_count;
    for (i = 1; i < n; i++) begin
      v = req_mem[i];
      j = i;
      while (j > 0 && req_mem[j-1] > v) begin
        req_mem[j] = req_mem[j-1];
        j--;
      end
      req_mem[j] = v;
    end
    // first entry above the head, or the batch end
    split = n;
    for (i = n; i > 0; i--)
      if (req_mem[i-1] > cyl_t'(head_start)) split = i - 1;
    last_cyl   = (disk_cyls == 0) ? cyl_t'(0) : cyl_t'(disk_cyls - 1);
    head_pos   = cyl_t'(head_start);
    travel_acc = '0;
    if (upward) begin
      for (i = split; i < n; i++) begin
        move_head(req_mem[i]);
        if (split == 0 && i == n - 1) begin
          sweep_wrap(last_cyl, '0, last_cyl);
          head_pos = req_mem[i];
        end
        note_result(req_mem[i], split == 0 && i == n - 1);
      end
      if (split > 0) begin
        sweep_wrap(last_cyl, '0, last_cyl);
        for (i = 0; i < split; i++) begin
          move_head(req_mem[i]);
          note_result(req_mem[i], i == split - 1);
        end
      end
    end else begin
      for (i = split; i > 0; i--) begin
        move_head(req_mem[i-1]);
        if (split == n && i == 1) begin
          sweep_wrap('0, last_cyl, last_cyl);
          head_pos = req_mem[0];
        end
        note_result(req_mem[i-1], split == n && i == 1);
      end
      if (split < n) begin
        sweep_wrap('0, last_cyl, last_cyl);
        for (i = n; i > split; i--) begin
          move_head(req_mem[i-1]);
          note_result(req_mem[i-1], i - 1 == split);
        end
      end
    end
    req_count = 0;
  endfunction

  always @(posedge clk) begin : watch
    service_t got, want;
    if (!rst_n) begin
      disk_cyls  = DISK_CYLINDERS_RESET;
      head_start = '0;
      upward     = 1'b1;
      req_count  = 0;
      head_pos   = '0;
      travel_acc = '0;
      service_q.delete();
    end else begin
      if (out_tvalid && out_tready) begin
        got.cylinder  = out_tdata[CYLINDER_BITS-1:0];
        got.movement  = out_tdata[CYLINDER_BITS +: TRAVEL_W];
        got.final_res = out_tlast;
        if (service_q.size() == 0) begin
          $error("unexpected result: served_cylinder %0d movement_so_far %0d final_res %0b",
                 got.cylinder, got.movement, got.final_res);
          fail_count++;
        end else begin
          want = service_q.pop_front();
          if (got.cylinder !== want.cylinder) begin
            $error("served_cylinder: expected %0d, got %0d", want.cylinder, got.cylinder);
            fail_count++;
          end
          if (got.movement !== want.movement) begin
            $error("movement_so_far: expected %0d, got %0d", want.movement, got.movement);
            fail_count++;
          end
          if (got.final_res !== want.final_res) begin
            $error("final_res: expected %0b, got %0b", want.final_res, got.final_res);
            fail_count++;
          end
        end
      end
      if (cfg_we) begin
        case (cfg_index)
          REG_DISK_CYLINDERS: disk_cyls  = cfg_wdata;
          REG_START_HEAD:     head_start = cfg_wdata;
          REG_SWEEP_UP:       upward     = cfg_wdata[0];
          default: ;
        endcase
      end
      if (in_tvalid && in_tready) begin
        // a full store drops the request, its end mark still counts
        if (req_count < MAX_REQUESTS) begin
          req_mem[req_count] = in_tdata[CYLINDER_BITS-1:0];
          req_count++;
        end
        if (in_tlast) schedule_batch();
      end
    end
    pending_results = service_q.size();
  end

endmodule

[verif/cscan_disk_scheduler_tb.sv]
// testbench top of the c-scan disk scheduler: stimulus, idling and verdict
`timescale 1ns / 1ps
module cscan_disk_scheduler_tb;
  import cscan_pkg::*;

  localparam int CYL_W          = 16;
  localparam int MAX_REQ        = 64;
  localparam int SETTLE_CYCLES  = 16;     // block winds down after its last result
  localparam int HOLD_CYCLES    = 600;    // long receiver hold-off
  localparam int WATCHDOG_LIMIT = 20000;  // cycles with no request or result moving
  localparam int PHASE_ITEMS    = 10;

  typedef logic [CYL_W-1:0] cyl_t;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  logic      cfg_we    = 1'b0;
  cfg_idx_t  cfg_index = REG_DISK_CYLINDERS;
  cfg_word_t cfg_wdata = '0;

  logic                              in_tvalid = 1'b0;
  logic                              in_tready;
  logic [((CYL_W+7)/8)*8-1:0]        in_tdata  = '0;   // cylinder
  logic                              in_tlast  = 1'b0; // batch_end

  logic                              out_tvalid;
  logic                              out_tready = 1'b0;
  // served_cylinder, movement_so_far, zero padding
  logic [((CYL_W+TRAVEL_W+7)/8)*8-1:0] out_tdata;
  logic                              out_tlast;        // final_res

  int unsigned fail_count;
  int unsigned pending_results;

  // idling knobs, percent of cycles
  int send_idle_pct = 0;
  int recv_idle_pct = 0;

  // hold-off handshake between the stimulus and the receiver process
  int holds_asked = 0;
  int holds_done  = 0;
  int hold_left   = 0;

  int quiet_cycles = 0;

  // current register values, used to aim the cylinders
  cfg_word_t cur_disk = DISK_CYLINDERS_RESET;
  cfg_word_t cur_head = '0;

  always #10 clk = ~clk;

  cscan_disk_scheduler #(
    .MAX_REQUESTS (MAX_REQ),
    .CYLINDER_BITS(CYL_W)
  ) i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast)
  );

  cscan_disk_scheduler_checker #(
    .MAX_REQUESTS (MAX_REQ),
    .CYLINDER_BITS(CYL_W)
  ) i_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .in_tvalid      (in_tvalid),
    .in_tready      (in_tready),
    .in_tdata       (in_tdata),
    .in_tlast       (in_tlast),
    .out_tvalid     (out_tvalid),
    .out_tready     (out_tready),
    .out_tdata      (out_tdata),
    .out_tlast      (out_tlast),
    .fail_count     (fail_count),
    .pending_results(pending_results)
  );

  // receiver: random back-pressure, or a long hold-off when the stimulus asks for one
  always @(negedge clk) begin
    if (hold_left != 0) begin
      out_tready <= 1'b0;
      hold_left  <= hold_left - 1;
    end else if (holds_done != holds_asked) begin
      out_tready <= 1'b0;
      hold_left  <= HOLD_CYCLES;
      holds_done <= holds_done + 1;
    end else begin
      out_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  // watchdog: a run that stops moving is a failure
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("tb: failure");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // one request; entered and left at a falling edge, valid stays up between back-to-back requests
  task automatic send_request(input cyl_t cyl, input logic last);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= cyl;
    in_tlast  <= last;
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
  endtask

  // writes all three registers; only called with the block idle
  task automatic program_disk(input cfg_word_t dc, input cfg_word_t hd, input logic up);
    cfg_we    <= 1'b1;
    cfg_index <= REG_DISK_CYLINDERS;
    cfg_wdata <= dc;
    @(negedge clk);
    cfg_index <= REG_START_HEAD;
    cfg_wdata <= hd;
    @(negedge clk);
    cfg_index <= REG_SWEEP_UP;
    cfg_wdata <= cfg_word_t'(up);
    @(negedge clk);
    cfg_we   <= 1'b0;
    cur_disk  = dc;
    cur_head  = hd;
  endtask

  // sender pauses until every predicted result is back and the block has settled
  task automatic drain_results;
    in_tvalid <= 1'b0;
    while (pending_results != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic directed_batch(input cfg_word_t dc, input cfg_word_t hd, input logic up,
                                input cyl_t vals [$]);
    int k;
    drain_results();
    program_disk(dc, hd, up);
    for (k = 0; k < vals.size(); k++) send_request(vals[k], k == vals.size() - 1);
  endtask

  // mostly on the disk, with some head hits, extremes and off-disk cylinders
  function automatic cyl_t pick_cylinder();
    int r;
    r = $urandom_range(0, 9);
    if (r < 6)
      return (cur_disk == 0) ? cyl_t'(0) : cyl_t'($urandom_range(0, cur_disk - 1));
    else if (r == 6)
      return cyl_t'(cur_head);
    else if (r == 7)
      return cyl_t'($urandom_range(0, 65535));
    else if (r == 8)
      return (cur_disk == 0) ? cyl_t'(0) : cyl_t'(cur_disk - 1);
    else
      return ($urandom_range(0, 1) != 0) ? '1 : '0;
  endfunction

  task automatic send_batch(input int size);
    int k;
    for (k = 0; k < size; k++) send_request(pick_cylinder(), k == size - 1);
  endtask

  // new random geometry between phases, extremes weighted in
  task automatic program_random_disk;
    cfg_word_t dc, hd;
    int        r;
    drain_results();
    r = $urandom_range(0, 9);
    case (r)
      0:       dc = '0;
      1:       dc = 16'd1;
      2:       dc = '1;
      3, 4, 5: dc = DISK_CYLINDERS_RESET;
      default: dc = cfg_word_t'($urandom_range(1, 65535));
    endcase
    r = $urandom_range(0, 9);
    case (r)
      0:       hd = '0;
      1:       hd = '1;
      2:       hd = (dc == 0) ? cfg_word_t'(0) : dc - 1;
      default: hd = (dc == 0) ? cfg_word_t'(0) : cfg_word_t'($urandom_range(0, dc - 1));
    endcase
    program_disk(dc, hd, logic'($urandom_range(0, 1)));
  endtask

  initial begin : stimulus
    int regime, phase, sent, size, r;

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed part, no idling
    // single request on the head: nothing above it
    directed_batch(16'd200, 16'd0, 1'b1, '{16'd0});
    // upward from 0 with the top code as an off-disk request
    directed_batch(16'd200, 16'd0, 1'b1, '{16'd199, 16'd50, 16'hFFFF, 16'd0, 16'd100});
    // downward across the head, both parts filled
    directed_batch(16'd200, 16'd100, 1'b0,
                   '{16'd10, 16'd150, 16'd100, 16'd199, 16'd30, 16'd180});
    // upward with everything above the head: empty second part
    directed_batch(16'd200, 16'd100, 1'b1, '{16'd120, 16'd101, 16'd199});
    // downward with nothing above the head
    directed_batch(16'd200, 16'd100, 1'b0, '{16'd100, 16'd5, 16'd0});
    // zero cylinders on the disk, head at the top code
    directed_batch(16'd0, 16'hFFFF, 1'b1, '{16'hFFFF, 16'd0, 16'd32768});
    // largest disk, downward with everything above the head
    directed_batch(16'hFFFF, 16'd0, 1'b0, '{16'd65534, 16'd1});

    // pressure: the receiver holds off while two batches are offered, the second overflowing
    send_idle_pct = 11;
    recv_idle_pct = 59;
    program_random_disk();
    holds_asked <= holds_asked + 1;
    send_batch(12);
    send_batch(MAX_REQ + 2);

    // random part: sender light / receiver heavy, then swapped, then no idling
    for (regime = 0; regime < 3; regime++) begin
      case (regime)
        0: begin
          send_idle_pct = 11;
          recv_idle_pct = 59;
        end
        1: begin
          send_idle_pct = 59;
          recv_idle_pct = 11;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      for (phase = 0; phase < 3; phase++) begin
        program_random_disk();
        sent = 0;
        while (sent < PHASE_ITEMS) begin
          // mostly short batches, a few long ones and the odd overflow
          r = $urandom_range(0, 99);
          if (r < 80)      size = $urandom_range(1, 8);
          else if (r < 95) size = $urandom_range(9, 24);
          else if (r < 98) size = $urandom_range(25, MAX_REQ);
          else             size = $urandom_range(MAX_REQ + 1, MAX_REQ + 4);
          send_batch(size);
          sent += size;
        end
      end
    end

    drain_results();
    if (fail_count == 0 && pending_results == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule
